// File: rtl/core/fmo_pkg.sv
// fmo_pkg: shared types, constants and tables of the fm phase accumulator oscillator
// holds the microprogram, the control word layout and the quarter-wave sine generator
// no dependencies
package fmo_pkg;

   // sine table geometry
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int TAB_BITS         = $clog2(SINE_TABLE_DEPTH);
   localparam int QUARTER          = SINE_TABLE_DEPTH / 4;

   // fm modes
   typedef enum logic [1:0] {
      FM_NONE     = 2'd0,
      FM_LINEAR   = 2'd1,
      FM_RELATIVE = 2'd2,
      FM_THRU_0   = 2'd3
   } fm_mode_type;

   // index limits, q10.16
   localparam logic [25:0] IDX_MAX_GENERAL  = 26'd65536000;
   localparam logic [25:0] IDX_MAX_RELATIVE = 26'd1966080;

   // configuration register indexes
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type CSR_BASE_INCREMENT  = 3'd0;
   localparam csr_addr_type CSR_FM_MODE         = 3'd1;
   localparam csr_addr_type CSR_MOD_INDEX       = 3'd2;
   localparam csr_addr_type CSR_HZ_TO_INCREMENT = 3'd3;
   localparam csr_addr_type CSR_NEGATIVE_WRAP   = 3'd4;

   typedef struct packed {
      logic [31:0] base_increment;
      fm_mode_type fm_mode;
      logic [25:0] mod_index;
      logic [39:0] hz_to_increment;
      logic        negative_wrap;
   } cfg_type;

   // datapath operations, one per microinstruction
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PROD_P,
      OP_PROD_LO,
      OP_LIN_D,
      OP_REL_D,
      OP_INC,
      OP_PHASE,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_NO_FM,
      COND_RELATIVE,
      COND_OUT_BUSY
   } cond_type;

   localparam int PROG_LEN = 9;
   localparam int STEP_W   = $clog2(PROG_LEN);
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT  = STEP_W'(0);
   localparam step_type STEP_PROD  = STEP_W'(1);
   localparam step_type STEP_HZ_LO = STEP_W'(2);
   localparam step_type STEP_HZ_HI = STEP_W'(3);
   localparam step_type STEP_REL   = STEP_W'(4);
   localparam step_type STEP_INC   = STEP_W'(5);
   localparam step_type STEP_PHASE = STEP_W'(6);
   localparam step_type STEP_ROM   = STEP_W'(7);
   localparam step_type STEP_EMIT  = STEP_W'(8);
   localparam step_type PROG_LAST  = STEP_EMIT;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic fm;
      logic relative;
   } dp_status_type;

   typedef struct packed {
      logic in_xfer;
      logic fm;
      logic relative;
      logic out_busy;
   } seq_status_type;

   // microprogram: taken jump goes to target, otherwise the next step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_WAIT:  word = '{op: OP_LOAD,    cond: COND_NO_INPUT, target: STEP_WAIT};
         STEP_PROD:  word = '{op: OP_PROD_P,  cond: COND_NO_FM,    target: STEP_INC};
         STEP_HZ_LO: word = '{op: OP_PROD_LO, cond: COND_RELATIVE, target: STEP_REL};
         STEP_HZ_HI: word = '{op: OP_LIN_D,   cond: COND_ALWAYS,   target: STEP_INC};
         STEP_REL:   word = '{op: OP_REL_D,   cond: COND_NEVER,    target: STEP_WAIT};
         STEP_INC:   word = '{op: OP_INC,     cond: COND_NEVER,    target: STEP_WAIT};
         STEP_PHASE: word = '{op: OP_PHASE,   cond: COND_NEVER,    target: STEP_WAIT};
         STEP_ROM:   word = '{op: OP_NOP,     cond: COND_NEVER,    target: STEP_WAIT};
         STEP_EMIT:  word = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: STEP_EMIT};
         default:    word = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return word;
   endfunction

   // quarter-wave sine magnitude for table position j, 0 <= j <= QUARTER
   // q30 taylor series to x^11 in horner form, then rounded to q15
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic logic [14:0] sine_mag(input int j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (HALF_PI_Q30 * (64'(j) * 64'd4)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

// File: rtl/core/fmo_sine_rom.sv
// fmo_sine_rom: full-wave sine lookup built on a quarter-wave constant table
// registered read
// depends on fmo_pkg
module fmo_sine_rom (
   input  logic                         clock,
   input  logic [fmo_pkg::TAB_BITS-1:0] addr,
   output logic signed [15:0]           sample
);
   import fmo_pkg::*;

   localparam int QW = TAB_BITS - 1;

   logic [14:0]        qtab [QUARTER+1];
   logic [1:0]         quad;
   logic [QW-1:0]      j_off;
   logic [QW-1:0]      j_sel;
   logic [14:0]        mag;
   logic signed [15:0] sample_in;
   logic signed [15:0] sample_ff;

   for (genvar g = 0; g <= QUARTER; g++) begin : gen_tab
      localparam logic [14:0] MAG = sine_mag(g);
      assign qtab[g] = MAG;
   end

   always_comb begin
      quad  = addr[TAB_BITS-1 -: 2];
      j_off = {1'b0, addr[TAB_BITS-3:0]};
      // odd quadrants run the table backward
      j_sel = quad[0] ? (QW'(QUARTER) - j_off) : j_off;
      mag   = qtab[j_sel];
      sample_in = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

// File: rtl/core/fmo_seq.sv
// fmo_seq: microcode sequencer, step counter plus control store lookup
// issues one datapath operation per cycle and takes conditional jumps
// depends on fmo_pkg
module fmo_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  fmo_pkg::seq_status_type status,
   output fmo_pkg::op_type         op,
   output logic                    in_ready
);
   import fmo_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      jump;

   always_comb begin
      word = ucode_rom(step_ff);
      case (word.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_INPUT: jump = !status.in_xfer;
         COND_NO_FM:    jump = !status.fm;
         COND_RELATIVE: jump = status.relative;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b0;
      endcase
      if (jump) begin
         step_in = word.target;
      end else if (step_ff == PROG_LAST) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
      op       = word.op;
      in_ready = (step_ff == STEP_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= PROG_LAST)
      else $error("step counter past end of program");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_WAIT && !status.in_xfer) |=> (step_ff == STEP_WAIT))
      else $error("sequencer left wait step without an input transfer");

endmodule

// File: rtl/core/fmo_dpath.sv
// fmo_dpath: phase datapath with one shared multiplier, increment saturation and wrap
// driven one operation per cycle by fmo_seq; holds the sine lookup instance
// depends on fmo_pkg, fmo_sine_rom
module fmo_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  fmo_pkg::op_type        op,
   input  logic                   in_xfer,
   input  logic signed [15:0]     mod_left,
   input  logic signed [15:0]     mod_right,
   input  logic                   restart,
   input  fmo_pkg::cfg_type       cfg,
   output fmo_pkg::dp_status_type status,
   output logic signed [15:0]     sample,
   output logic                   wrapped
);
   import fmo_pkg::*;

   localparam logic signed [38:0] INC_MAX = 39'sd4294967295;
   localparam logic signed [38:0] INC_MIN = -39'sd4294967295;
   localparam logic signed [33:0] PH_ONE  = 34'sd4294967296;
   localparam logic signed [33:0] PH_MIN  = -34'sd4294967296;

   logic signed [16:0] mod_sum;
   logic [16:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [25:0]        idx_clamp;
   logic               relative;
   logic               fm;
   logic [25:0]        p_ff, p_in;
   logic [25:0]        acc_ff, acc_in;
   logic [36:0]        d_ff, d_in;
   logic signed [32:0] inc_ff, inc_in;
   logic signed [32:0] phase_ff, phase_in;
   logic               wrap_ff, wrap_in;
   logic [25:0]        mul_a;
   logic [31:0]        mul_b;
   logic [57:0]        prod;
   logic [42:0]        lin_sum;
   logic signed [38:0] inc_wide;
   logic signed [38:0] inc_sat;
   logic signed [33:0] ph_sum;
   logic signed [33:0] ph_adj;

   always_comb begin
      relative = (cfg.fm_mode == FM_RELATIVE);
      if (relative) begin
         idx_clamp = (cfg.mod_index > IDX_MAX_RELATIVE) ? IDX_MAX_RELATIVE : cfg.mod_index;
      end else begin
         idx_clamp = (cfg.mod_index > IDX_MAX_GENERAL) ? IDX_MAX_GENERAL : cfg.mod_index;
      end
      fm = (idx_clamp != '0) && (cfg.fm_mode != FM_NONE);
      status.fm       = fm;
      status.relative = relative;

      // sum of both channels, q.16
      mod_sum = {mod_left[15], mod_left} + {mod_right[15], mod_right};

      // shared multiplier operand select
      case (op)
         OP_PROD_P: begin
            mul_a = {9'b0, mag_ff};
            mul_b = {6'b0, idx_clamp};
         end
         OP_PROD_LO: begin
            mul_a = p_ff;
            mul_b = {8'b0, cfg.hz_to_increment[23:0]};
         end
         OP_LIN_D: begin
            mul_a = p_ff;
            mul_b = {16'b0, cfg.hz_to_increment[39:24]};
         end
         default: begin
            mul_a = p_ff;
            mul_b = cfg.base_increment;
         end
      endcase
      prod    = 58'(mul_a) * 58'(mul_b);
      lin_sum = 43'(prod[41:0]) + 43'(acc_ff);

      // fm term applied with the sign of the modulation, then saturated
      if (neg_ff) begin
         inc_wide = $signed({7'b0, cfg.base_increment}) - $signed({2'b0, d_ff});
      end else begin
         inc_wide = $signed({7'b0, cfg.base_increment}) + $signed({2'b0, d_ff});
      end
      if (inc_wide > INC_MAX) begin
         inc_sat = INC_MAX;
      end else if (inc_wide < INC_MIN) begin
         inc_sat = INC_MIN;
      end else begin
         inc_sat = inc_wide;
      end

      // phase step, wrap above one, optional wrap below zero, floor at minus one
      ph_sum  = {phase_ff[32], phase_ff} + {inc_ff[32], inc_ff};
      wrap_in = wrap_ff;
      ph_adj  = ph_sum;
      if (ph_sum >= PH_ONE) begin
         ph_adj = ph_sum - PH_ONE;
      end else if (fm && ph_sum[33] && cfg.negative_wrap) begin
         ph_adj = ph_sum + PH_ONE;
      end
      if (ph_adj < PH_MIN) begin
         ph_adj = PH_MIN;
      end

      mag_in   = mag_ff;
      neg_in   = neg_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      d_in     = d_ff;
      inc_in   = inc_ff;
      phase_in = phase_ff;
      case (op)
         OP_LOAD: begin
            if (in_xfer) begin
               neg_in = mod_sum[16];
               mag_in = mod_sum[16] ? 17'(-mod_sum) : 17'(mod_sum);
               if (restart) begin
                  phase_in = '0;
               end
            end
         end
         OP_PROD_P:  p_in   = prod[41:16];
         OP_PROD_LO: acc_in = prod[49:24];
         OP_LIN_D:   d_in   = {2'b0, lin_sum[42:8]};
         OP_REL_D:   d_in   = prod[52:16];
         OP_INC:     inc_in = fm ? $signed(inc_sat[32:0]) : $signed({1'b0, cfg.base_increment});
         OP_PHASE: begin
            phase_in = $signed(ph_adj[32:0]);
            wrap_in  = (ph_sum >= PH_ONE) || (fm && ph_sum[33] && cfg.negative_wrap);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      d_ff    <= d_in;
      inc_ff  <= inc_in;
      wrap_ff <= wrap_in;
   end

   // lookup index is the top bits of the phase fraction
   fmo_sine_rom u_rom (
      .clock  (clock),
      .addr   (phase_ff[31 -: TAB_BITS]),
      .sample (sample)
   );

   assign wrapped = wrap_ff;

   a_inc_sat: assert property (@(posedge clock) disable iff (reset)
      (op == OP_INC) |=> !(inc_ff[32] && (inc_ff[31:0] == '0)))
      else $error("increment outside saturation limits");

endmodule

// File: rtl/core/fm_phase_accumulator_sine_osc_top.sv
// fm_phase_accumulator_sine_osc_top: fm phase accumulator sine oscillator, top level
// configuration registers, stream handshakes and result register
// depends on fmo_pkg, fmo_seq, fmo_dpath (and through it fmo_sine_rom)
//
//  channel  dir  transfer when               payload
//  req      in   req_tvalid & req_tready     tdata: mod_left, mod_right; tuser: restart
//  rsp      out  rsp_tvalid & rsp_tready     tdata: sample_left, sample_right; tuser: wrapped
//  csr      in   csr_we                      csr_addr selects register, csr_wdata value
//
// an item runs load, modulation product, the hz or relative products when fm is on in any
// mode, then increment, phase, table read and emit; the steps are set by the microprogram,
// which makes one pass per product through the single shared multiplier (two for the 40-bit factor)
// reset is synchronous; it restores the register defaults and zero phase
// a result waits in the output register; the next input transfer is taken
// meanwhile, and the sequencer holds at its last step only while that register is full and rsp_tready is low
module fm_phase_accumulator_sine_osc_top (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // mod_left [15:0], mod_right [31:16]
   input  logic                  req_tuser,  // restart
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // sample_left [15:0], sample_right [31:16]
   output logic                  rsp_tuser,  // wrapped
   // configuration writes
   input  logic                  csr_we,
   input  fmo_pkg::csr_addr_type csr_addr,
   input  logic [39:0]           csr_wdata
);
   import fmo_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   op_type             op;
   logic               in_ready;
   logic               in_xfer;
   logic               out_busy;
   logic               emit;
   dp_status_type      dp_status;
   seq_status_type     seq_status;
   logic signed [15:0] sample;
   logic               wrapped;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_sample_ff, rsp_sample_in;
   logic               rsp_wrap_ff, rsp_wrap_in;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_BASE_INCREMENT:  cfg_in.base_increment  = csr_wdata[31:0];
            CSR_FM_MODE:         cfg_in.fm_mode         = fm_mode_type'(csr_wdata[1:0]);
            CSR_MOD_INDEX:       cfg_in.mod_index       = csr_wdata[25:0];
            CSR_HZ_TO_INCREMENT: cfg_in.hz_to_increment = csr_wdata[39:0];
            CSR_NEGATIVE_WRAP:   cfg_in.negative_wrap   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_increment  <= '0;
         cfg_ff.fm_mode         <= FM_THRU_0;
         cfg_ff.mod_index       <= '0;
         cfg_ff.hz_to_increment <= '0;
         cfg_ff.negative_wrap   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshakes
   assign req_tready = in_ready;
   assign in_xfer    = req_tvalid && in_ready;
   // result slot still holds an untaken transfer
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign emit       = (op == OP_EMIT) && !out_busy;

   always_comb begin
      seq_status.in_xfer  = in_xfer;
      seq_status.fm       = dp_status.fm;
      seq_status.relative = dp_status.relative;
      seq_status.out_busy = out_busy;
   end

   fmo_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .status   (seq_status),
      .op       (op),
      .in_ready (in_ready)
   );

   fmo_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .in_xfer   (in_xfer),
      .mod_left  (req_tdata[15:0]),
      .mod_right (req_tdata[31:16]),
      .restart   (req_tuser),
      .cfg       (cfg_ff),
      .status    (dp_status),
      .sample    (sample),
      .wrapped   (wrapped)
   );

   // result register
   always_comb begin
      rsp_valid_in  = emit || out_busy;
      rsp_sample_in = emit ? sample : rsp_sample_ff;
      rsp_wrap_in   = emit ? wrapped : rsp_wrap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_wrap_ff   <= rsp_wrap_in;
   end

   // both channels carry the same sine value
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sample_ff, rsp_sample_ff};
   assign rsp_tuser  = rsp_wrap_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(op) == OP_EMIT))
      else $error("result appeared without an emit step");

endmodule

// File: verif/fm_phase_accumulator_sine_osc_top_test.sv
// fm_phase_accumulator_sine_osc_top_test: self-checking bench for the fm sine oscillator
// table-driven probes, then randomized settings and samples under four idle profiles
// depends on fmo_pkg and fm_phase_accumulator_sine_osc_top
`timescale 1ns / 100ps

module fm_phase_accumulator_sine_osc_top_test;
   import fmo_pkg::*;

   // one oscillator output: the fields of rsp_tdata / rsp_tuser, left sample first
   typedef struct packed {
      logic [15:0] sample_left;
      logic [15:0] sample_right;
      logic        wrapped;
   } tone_type;

   // one directed probe: optional reprogramming, then one modulation sample
   typedef struct packed {
      logic        reprogram;
      logic [31:0] base;
      fm_mode_type mode;
      logic [25:0] index;
      logic [39:0] hz;
      logic        nwrap;
      logic [15:0] left;
      logic [15:0] right;
      logic        restart;
      logic        known;      // result typed in below, otherwise predicted
      logic [15:0] sample;
      logic        wrapped;
   } probe_row_type;

   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
   localparam int DRAIN_CYCLES   = 16;    // settle time after the last result, longer than one item
   localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch
   localparam int SEG_ITEMS      = 50;    // samples per random setting

   localparam logic signed [63:0] PHASE_ONE = 64'sd1 << 32;
   localparam logic signed [63:0] INC_CAP   = 64'sd4294967295;

   localparam logic [31:0] QTR  = 32'h4000_0000;
   localparam logic [39:0] HZ_F = 40'hFF_FFFF_FFFF;
   localparam logic [25:0] IX_F = 26'h3FF_FFFF;

   localparam int NUM_PROBES = 23;
   // columns: reprogram, base, mode, index, hz, nwrap, left, right, restart,
   //          known, sample, wrapped
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      // reset defaults: index zero keeps fm off, increment zero holds phase at zero
      '{1'b0, 32'd0, FM_THRU_0, 26'd0, 40'd0, 1'b1,
        16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{1'b0, 32'd0, FM_THRU_0, 26'd0, 40'd0, 1'b1,
        16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0},
      // quarter-cycle steps without fm: peak, zero, trough, wrap back to zero
      '{1'b1, QTR, FM_NONE, 26'd0, 40'd0, 1'b1,
        16'h0000, 16'h0000, 1'b1, 1'b1, 16'h7FFF, 1'b0},
      '{1'b0, QTR, FM_NONE, 26'd0, 40'd0, 1'b1,
        16'hFFFF, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b0},
      '{1'b0, QTR, FM_NONE, 26'd0, 40'd0, 1'b1,
        16'h1234, 16'h8000, 1'b0, 1'b1, 16'h8001, 1'b0},
      '{1'b0, QTR, FM_NONE, 26'd0, 40'd0, 1'b1,
        16'h7FFF, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1},
      // largest plain step, mode none ignores a huge index
      '{1'b1, 32'hFFFF_FFFF, FM_NONE, IX_F, HZ_F, 1'b0,
        16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'hFFFF_FFFF, FM_NONE, IX_F, HZ_F, 1'b0,
        16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      // through zero at full index: saturated steps both ways, wrap below
      '{1'b1, 32'd0, FM_THRU_0, IDX_MAX_GENERAL, HZ_F, 1'b1,
        16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'd0, FM_THRU_0, IDX_MAX_GENERAL, HZ_F, 1'b1,
        16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'd0, FM_THRU_0, IDX_MAX_GENERAL, HZ_F, 1'b1,
        16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      // oversize index, no negative wrap: phase runs down to the floor
      '{1'b1, 32'h0010_0000, FM_THRU_0, IX_F, HZ_F, 1'b0,
        16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h0010_0000, FM_THRU_0, IX_F, HZ_F, 1'b0,
        16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h0010_0000, FM_THRU_0, IX_F, HZ_F, 1'b0,
        16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      // linear, moderate numbers, zero mean first
      '{1'b1, 32'h8000_0000, FM_LINEAR, 26'h001_0000, 40'h01_0000_0000, 1'b1,
        16'h4000, 16'hC000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h8000_0000, FM_LINEAR, 26'h001_0000, 40'h01_0000_0000, 1'b1,
        16'h1234, 16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h8000_0000, FM_LINEAR, 26'h001_0000, 40'h01_0000_0000, 1'b1,
        16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      // relative with index clipped to the relative limit
      '{1'b1, 32'h0400_0000, FM_RELATIVE, IX_F, 40'd0, 1'b1,
        16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h0400_0000, FM_RELATIVE, IX_F, 40'd0, 1'b1,
        16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 32'h0400_0000, FM_RELATIVE, IX_F, 40'd0, 1'b1,
        16'h0001, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      // relative with zero index: plain path
      '{1'b1, 32'h0400_0000, FM_RELATIVE, 26'd0, HZ_F, 1'b1,
        16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      // fm on but zero hz factor
      '{1'b1, 32'h1234_5678, FM_LINEAR, 26'd1, 40'd0, 1'b0,
        16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
      // small negative linear step, phase goes negative and stays there
      '{1'b1, 32'd0, FM_LINEAR, 26'h001_0000, HZ_F, 1'b0,
        16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0}
   };

   // dut ports
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // mod_left [15:0], mod_right [31:16]
   logic                  req_tuser  = 1'b0; // restart
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // sample_left [15:0], sample_right [31:16]
   logic                  rsp_tuser;         // wrapped
   logic                  csr_we     = 1'b0;
   csr_addr_type          csr_addr   = CSR_BASE_INCREMENT;
   logic [39:0]           csr_wdata  = '0;

   // oscillator mirror: settings as last written, and the running phase
   logic [31:0]           osc_base;
   fm_mode_type           osc_mode;
   logic [25:0]           osc_index;
   logic [39:0]           osc_hz;
   logic                  osc_nwrap;
   logic signed [63:0]    osc_phase;
   logic [15:0]           sine_lut [SINE_TABLE_DEPTH];

   tone_type              pending_tones [$];

   // idle profile and back-pressure requests
   int unsigned           send_idle_pct = 0;
   int unsigned           stall_pct     = 0;
   int unsigned           hold_requests = 0;
   int unsigned           holds_served  = 0;
   int unsigned           hold_left     = 0;

   // bookkeeping
   int unsigned           mismatch_count = 0;
   int unsigned           tones_checked  = 0;
   int unsigned           wraps_seen     = 0;
   int unsigned           settings_used  = 0;
   int unsigned           quiet_cycles   = 0;

   fm_phase_accumulator_sine_osc_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // full sine table, quadrant folding over a q30 taylor quarter wave
   function automatic void build_sine_lut();
      logic [63:0] u, r, x, x2, t, s, v;
      logic [1:0]  quad;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         u    = 64'(k) * 64'd4;
         quad = 2'(u / SINE_TABLE_DEPTH);
         r    = u % SINE_TABLE_DEPTH;
         if (quad[0]) begin
            r = SINE_TABLE_DEPTH - r;
         end
         x  = (HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         if (quad[1]) begin
            v = -v;
         end
         sine_lut[k] = v[15:0];
      end
   endfunction

   // one sample step of the oscillator: new phase, wrap flag, table sine
   function automatic tone_type advance_phase(input logic [15:0] left,
                                              input logic [15:0] right,
                                              input logic restart);
      logic signed [63:0] m;
      logic signed [63:0] inc;
      logic [63:0]        mag;
      logic [63:0]        p;
      logic [63:0]        d_mag;
      logic [127:0]       wide;
      logic [25:0]        idx_used;
      logic               fm_on;
      logic [9:0]         slot;
      tone_type           tone;
      m = $signed(left) + $signed(right);
      if (restart) begin
         osc_phase = '0;
      end
      // index limit depends on the mode
      idx_used = osc_index;
      if (osc_mode == FM_RELATIVE) begin
         if (idx_used > IDX_MAX_RELATIVE) idx_used = IDX_MAX_RELATIVE;
      end else if (idx_used > IDX_MAX_GENERAL) begin
         idx_used = IDX_MAX_GENERAL;
      end
      fm_on = (idx_used != '0) && (osc_mode != FM_NONE);
      inc   = $signed({32'd0, osc_base});
      tone.wrapped = 1'b0;
      if (fm_on) begin
         // magnitude first, sign last: the fm term truncates toward zero
         mag = (m < 0) ? -m : m;
         p   = (mag * idx_used) >> 16;
         if (osc_mode == FM_RELATIVE) begin
            d_mag = ({32'd0, osc_base} * p) >> 16;
         end else begin
            wide  = {64'd0, p} * {88'd0, osc_hz};
            d_mag = wide[95:32];
         end
         inc = (m < 0) ? inc - $signed(d_mag) : inc + $signed(d_mag);
         if (inc > INC_CAP) inc = INC_CAP;
         if (inc < -INC_CAP) inc = -INC_CAP;
      end
      osc_phase = osc_phase + inc;
      if (osc_phase >= PHASE_ONE) begin
         osc_phase    = osc_phase - PHASE_ONE;
         tone.wrapped = 1'b1;
      end else if (fm_on && osc_phase < 0 && osc_nwrap) begin
         osc_phase    = osc_phase + PHASE_ONE;
         tone.wrapped = 1'b1;
      end
      if (osc_phase < -PHASE_ONE) begin
         osc_phase = -PHASE_ONE;
      end
      // table index from the phase fraction
      slot = osc_phase[31:22];
      tone.sample_left  = sine_lut[slot];
      tone.sample_right = sine_lut[slot];
      return tone;
   endfunction

   // stop offering, wait for every result, then let the pipeline settle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_tones.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all five registers back to back; block must be idle
   task automatic program_osc(input logic [31:0] base, input fm_mode_type mode,
                              input logic [25:0] index, input logic [39:0] hz,
                              input logic nwrap);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_BASE_INCREMENT;
      csr_wdata <= 40'(base);
      @(posedge clock);
      csr_addr  <= CSR_FM_MODE;
      csr_wdata <= 40'(mode);
      @(posedge clock);
      csr_addr  <= CSR_MOD_INDEX;
      csr_wdata <= 40'(index);
      @(posedge clock);
      csr_addr  <= CSR_HZ_TO_INCREMENT;
      csr_wdata <= hz;
      @(posedge clock);
      csr_addr  <= CSR_NEGATIVE_WRAP;
      csr_wdata <= 40'(nwrap);
      @(posedge clock);
      csr_we    <= 1'b0;
      osc_base  = base;
      osc_mode  = mode;
      osc_index = index;
      osc_hz    = hz;
      osc_nwrap = nwrap;
      settings_used++;
   endtask

   // offer one modulation sample, with random idle cycles ahead of it;
   // tvalid is left high on return so a following transfer keeps it up
   task automatic push_sample(input logic [15:0] left, input logic [15:0] right,
                              input logic restart, input logic known, input tone_type typed);
      tone_type tone;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      tone = advance_phase(left, right, restart);
      pending_tones.push_back(known ? typed : tone);
   endtask

   // random settings; each field hits its extremes now and then
   task automatic program_random();
      logic [31:0] base;
      fm_mode_type mode;
      logic [25:0] index;
      logic [39:0] hz;
      case ($urandom_range(3))
         0: base = '0;
         1: base = '1;
         2: base = $urandom_range(32'h0800_0000);
         default: base = $urandom;
      endcase
      mode = fm_mode_type'($urandom_range(3));
      case ($urandom_range(5))
         0: index = '0;
         1: index = IDX_MAX_GENERAL;
         2: index = '1;
         3: index = 26'($urandom_range(IDX_MAX_GENERAL));
         default: index = 26'($urandom_range(32'h0004_0000));
      endcase
      case ($urandom_range(3))
         0: hz = '1;
         1: hz = 40'({$urandom, $urandom});
         default: hz = 40'($urandom >> $urandom_range(24));
      endcase
      quiesce();
      program_osc(base, mode, index, hz, 1'(($urandom_range(1))));
   endtask

   function automatic logic [15:0] random_mod();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls per profile, plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_tready   <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result checker: every result transfer against the oldest expectation
   always @(posedge clock) begin
      tone_type got;
      tone_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser};
         if (pending_tones.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_tones.pop_front();
            tones_checked++;
            if (got.wrapped) wraps_seen++;
            if (got.sample_left !== want.sample_left) begin
               $error("sample_left: expected %0d, actual %0d",
                      $signed(want.sample_left), $signed(got.sample_left));
               mismatch_count++;
            end
            if (got.sample_right !== want.sample_right) begin
               $error("sample_right: expected %0d, actual %0d",
                      $signed(want.sample_right), $signed(got.sample_right));
               mismatch_count++;
            end
            if (got.wrapped !== want.wrapped) begin
               $error("wrapped: expected %0b, actual %0b", want.wrapped, got.wrapped);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                  quiet_cycles, pending_tones.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      tone_type typed;
      build_sine_lut();
      // mirror starts at the register defaults
      osc_base  = '0;
      osc_mode  = FM_THRU_0;
      osc_index = '0;
      osc_hz    = '0;
      osc_nwrap = 1'b1;
      osc_phase = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed probes, no idling
      for (int i = 0; i < NUM_PROBES; i++) begin
         if (PROBES[i].reprogram) begin
            quiesce();
            program_osc(PROBES[i].base, PROBES[i].mode, PROBES[i].index,
                        PROBES[i].hz, PROBES[i].nwrap);
         end
         typed = {PROBES[i].sample, PROBES[i].sample, PROBES[i].wrapped};
         push_sample(PROBES[i].left, PROBES[i].right, PROBES[i].restart,
                     PROBES[i].known, typed);
      end

      // random part: four idle profiles, a few settings each
      for (int prof = 0; prof < 4; prof++) begin
         case (prof)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            program_random();
            // long receiver hold while the sender keeps offering: block backs up
            if (prof == 0 && seg == 1) hold_requests++;
            repeat (SEG_ITEMS) begin
               push_sample(random_mod(), random_mod(), 1'($urandom_range(15) == 0),
                           1'b0, '0);
            end
         end
      end

      quiesce();
      $display("ran %0d probes and %0d random samples over %0d settings and four idle profiles",
               NUM_PROBES, 12 * SEG_ITEMS, settings_used);
      $display("checked %0d results, %0d with the wrap flag set", tones_checked, wraps_seen);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/fmo_pkg.sv
rtl/core/fmo_sine_rom.sv
rtl/core/fmo_seq.sv
rtl/core/fmo_dpath.sv
rtl/core/fm_phase_accumulator_sine_osc_top.sv
verif/fm_phase_accumulator_sine_osc_top_test.sv
